FILE: design/pphd_pkg.sv
// ----------------------------------------------------------------------------
// Packed pixel half downscaler package
// Pixel formats, register indexes, reset values and the mask helpers that the
// downscaler uses.
// ----------------------------------------------------------------------------
`default_nettype none

package pphd_pkg;

  // Default geometry limits
  localparam int unsigned DEF_MAX_WIDTH  = 2048;
  localparam int unsigned DEF_MAX_HEIGHT = 2048;

  // Pixel and configuration data widths
  localparam int unsigned PIX_W     = 32;
  localparam int unsigned SUM_W     = PIX_W + 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;
  localparam int unsigned SIZE_W    = 12;
  localparam int unsigned NUM_CH    = 4;

  // Pixel formats
  typedef enum logic [1:0] {
    FMT_8BPP  = 2'd0,
    FMT_16BPP = 2'd1,
    FMT_24BPP = 2'd2,
    FMT_32BPP = 2'd3
  } pix_fmt_e;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_MASK    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_MASK      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_MASK    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE_MASK     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 3'd6;

  // Channel slots in the mask arrays
  localparam int unsigned CH_ALPHA = 0;
  localparam int unsigned CH_RED   = 1;
  localparam int unsigned CH_GREEN = 2;
  localparam int unsigned CH_BLUE  = 3;

  // Reset values
  localparam pix_fmt_e         RST_FORMAT     = FMT_32BPP;
  localparam logic [PIX_W-1:0] RST_ALPHA_MASK = 32'hFF00_0000;
  localparam logic [PIX_W-1:0] RST_RED_MASK   = 32'h00FF_0000;
  localparam logic [PIX_W-1:0] RST_GREEN_MASK = 32'h0000_FF00;
  localparam logic [PIX_W-1:0] RST_BLUE_MASK  = 32'h0000_00FF;

  // Bits that a pixel of the given format occupies
  function automatic logic [PIX_W-1:0] fmt_mask(pix_fmt_e fmt);
    logic [PIX_W-1:0] m;
    unique case (fmt)
      FMT_8BPP:  m = 32'h0000_00FF;
      FMT_16BPP: m = 32'h0000_FFFF;
      FMT_24BPP: m = 32'h00FF_FFFF;
      FMT_32BPP: m = 32'hFFFF_FFFF;
      default:   m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  // All bits from the lowest set bit of a mask upwards; clearing the rest of
  // a quarter sum drops the fraction below the channel's own lsb
  function automatic logic [PIX_W-1:0] keep_mask(logic [PIX_W-1:0] m);
    return m | (~m + 32'd1);
  endfunction

endpackage

`default_nettype wire

FILE: design/pphd_if.sv
// ----------------------------------------------------------------------------
// Packed pixel half downscaler channels
// Valid/ready request channels for source pixels and downscaled pixels.
// ----------------------------------------------------------------------------
`default_nettype none

interface pphd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] source_pixel;

  modport source (output valid, output source_pixel, input ready);
  modport sink   (input valid, input source_pixel, output ready);
endinterface

interface pphd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_pixel;
  logic        row_end;
  logic        frame_end;

  modport source (output valid, output out_pixel, output row_end, output frame_end,
                  input ready);
  modport sink   (input valid, input out_pixel, input row_end, input frame_end,
                  output ready);
endinterface

`default_nettype wire

FILE: design/pphd_ram.sv
// ----------------------------------------------------------------------------
// Generic single-write RAM
// One write port and one read port; read data registered, held without a read.
// ----------------------------------------------------------------------------
`default_nettype none

module pphd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                           wdata_i,
  input  wire logic                                       re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, hold when idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/packed_pixel_half_downscaler_top.sv
// ----------------------------------------------------------------------------
// Packed pixel half downscaler
// 2x2 box filter that halves a raster image in both directions.
// ----------------------------------------------------------------------------
// Usage:
//   src_i takes one source pixel per request in raster order; dst_o delivers
//   one pixel of the ceil(W/2) x ceil(H/2) image for every completed 2x2
//   block, with row_end on the last pixel of an output row and frame_end on
//   the last pixel of the frame. A 1x1 frame gives no output.
//   Configuration registers are written through cfg_we_i/cfg_idx_i/
//   cfg_wdata_i while the block is idle; they take effect at once.
//   Throughput is one source pixel per clock while dst_o does not hold the
//   pipeline full: each pixel makes at most one write into one of two line
//   banks (even and odd columns) or one read of both, and the two arithmetic
//   stages behind them are fully pipelined. A result passes through the
//   stage 1, stage 2 and output registers before it is valid on dst_o.
//   Reset clears the counters, the pipeline and the registers to their
//   defaults (32 bpp, ARGB masks, 1x1 frame). The line banks are not
//   cleared; an even row always fills them before an odd row reads them.
//   When dst_o stalls, the result holds in the output register and the two
//   stages behind it keep filling; src_i.ready drops only once they are full.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_pixel_half_downscaler_top
  import pphd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata_i,
  pphd_in_if.sink                   src_i,
  pphd_out_if.source                dst_o
);

  localparam int unsigned CW         = $clog2(MAX_WIDTH);
  localparam int unsigned RW         = $clog2(MAX_HEIGHT);
  localparam int unsigned WW         = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW         = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned BANK_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int unsigned BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  typedef struct packed {
    logic [PIX_W-1:0] bl;
    logic [PIX_W-1:0] cur;
    logic             single_row;
    logic             single_col;
    logic             row_end;
    logic             frame_end;
  } s1_t;

  // Configuration registers
  pix_fmt_e                     fmt_q;
  logic [NUM_CH-1:0][PIX_W-1:0] mask_q;
  logic [NUM_CH-1:0][PIX_W-1:0] keep_q;
  logic [WW-1:0]                width_q;
  logic [HW-1:0]                height_q;
  logic [31:0]                  size_v;
  logic [WW-1:0]                width_d;
  logic [HW-1:0]                height_d;

  // Position and previous pixel
  logic [CW-1:0]    col_q, col_d, col_eff;
  logic [RW-1:0]    row_q, row_d, row_eff;
  logic [PIX_W-1:0] left_q;

  // Front end decode
  logic [PIX_W-1:0] fm, cur, bl;
  logic             last_col, last_row, single_col, single_row, emit_ok;
  logic             in_acc;

  // Line banks
  logic               we_even, we_odd, ram_re;
  logic [BANK_AW-1:0] bank_addr;
  logic [PIX_W-1:0]   even_rd, odd_rd;

  // Pipeline
  logic                         s1_v_q, s2_v_q, out_v_q;
  s1_t                          s1_q;
  logic [NUM_CH-1:0][SUM_W-1:0] sum_c, s2_sum_q;
  logic [PIX_W-1:0]             p0, p1, s2_pal_q;
  logic                         s2_row_end_q, s2_frame_end_q;
  logic [PIX_W-1:0]             acc, res;
  logic [PIX_W-1:0]             out_pixel_q;
  logic                         out_row_end_q, out_frame_end_q;
  logic                         out_free, take2, take1, s1_go, s2_go;

  // ------------------------------------------------------------------
  // Configuration
  // ------------------------------------------------------------------

  // Clamp sizes to 1..MAX on write
  always_comb begin
    size_v = 32'(cfg_wdata_i[SIZE_W-1:0]);
    if (size_v == 32'd0) begin
      width_d  = WW'(1);
      height_d = HW'(1);
    end else begin
      width_d  = (size_v > 32'(MAX_WIDTH))  ? WW'(MAX_WIDTH)  : WW'(size_v);
      height_d = (size_v > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(size_v);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q            <= RST_FORMAT;
      mask_q[CH_ALPHA] <= RST_ALPHA_MASK;
      mask_q[CH_RED]   <= RST_RED_MASK;
      mask_q[CH_GREEN] <= RST_GREEN_MASK;
      mask_q[CH_BLUE]  <= RST_BLUE_MASK;
      keep_q[CH_ALPHA] <= keep_mask(RST_ALPHA_MASK);
      keep_q[CH_RED]   <= keep_mask(RST_RED_MASK);
      keep_q[CH_GREEN] <= keep_mask(RST_GREEN_MASK);
      keep_q[CH_BLUE]  <= keep_mask(RST_BLUE_MASK);
      width_q          <= WW'(1);
      height_q         <= HW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PIXEL_FORMAT: fmt_q <= pix_fmt_e'(cfg_wdata_i[1:0]);
        CFG_ALPHA_MASK: begin
          mask_q[CH_ALPHA] <= cfg_wdata_i;
          keep_q[CH_ALPHA] <= keep_mask(cfg_wdata_i);
        end
        CFG_RED_MASK: begin
          mask_q[CH_RED] <= cfg_wdata_i;
          keep_q[CH_RED] <= keep_mask(cfg_wdata_i);
        end
        CFG_GREEN_MASK: begin
          mask_q[CH_GREEN] <= cfg_wdata_i;
          keep_q[CH_GREEN] <= keep_mask(cfg_wdata_i);
        end
        CFG_BLUE_MASK: begin
          mask_q[CH_BLUE] <= cfg_wdata_i;
          keep_q[CH_BLUE] <= keep_mask(cfg_wdata_i);
        end
        CFG_SOURCE_WIDTH:  width_q  <= width_d;
        CFG_SOURCE_HEIGHT: height_q <= height_d;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Position decode
  // ------------------------------------------------------------------

  // Wrap a counter that a smaller size has left behind
  always_comb begin
    fm      = fmt_mask(fmt_q);
    cur     = src_i.source_pixel & fm;
    col_eff = (WW'(col_q) >= width_q)  ? '0 : col_q;
    row_eff = (HW'(row_q) >= height_q) ? '0 : row_q;

    last_col   = (WW'(col_eff) == (width_q - WW'(1)));
    last_row   = (HW'(row_eff) == (height_q - HW'(1)));
    single_col = last_col & ~col_eff[0];
    single_row = last_row & ~row_eff[0];
    emit_ok    = (col_eff[0] | single_col) & (row_eff[0] | single_row)
               & ~((width_q == WW'(1)) & (height_q == HW'(1)));
    bl         = single_col ? cur : (left_q & fm);
  end

  assign take1       = ~s1_v_q | take2;
  assign src_i.ready = take1;
  assign in_acc      = src_i.valid & take1;

  // Advance the raster position
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_eff + RW'(1);
      end else begin
        col_d = col_eff + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      left_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (in_acc) begin
        left_q <= cur;
      end
    end
  end

  // ------------------------------------------------------------------
  // Line banks: even rows write, odd rows read both halves of a pair
  // ------------------------------------------------------------------
  assign bank_addr = BANK_AW'(col_eff >> 1);
  assign we_even   = in_acc & ~row_eff[0] & ~col_eff[0];
  assign we_odd    = in_acc & ~row_eff[0] &  col_eff[0];
  assign ram_re    = in_acc & emit_ok & ~single_row;

  pphd_ram #(
    .WIDTH (PIX_W),
    .DEPTH (BANK_DEPTH)
  ) u_even_bank (
    .clk_i   (clk_i),
    .we_i    (we_even),
    .waddr_i (bank_addr),
    .wdata_i (cur),
    .re_i    (ram_re),
    .raddr_i (bank_addr),
    .rdata_o (even_rd)
  );

  pphd_ram #(
    .WIDTH (PIX_W),
    .DEPTH (BANK_DEPTH)
  ) u_odd_bank (
    .clk_i   (clk_i),
    .we_i    (we_odd),
    .waddr_i (bank_addr),
    .wdata_i (cur),
    .re_i    (ram_re),
    .raddr_i (bank_addr),
    .rdata_o (odd_rd)
  );

  // ------------------------------------------------------------------
  // Pipeline control
  // ------------------------------------------------------------------
  assign out_free = ~out_v_q | dst_o.ready;
  assign take2    = ~s2_v_q | out_free;
  assign s1_go    = s1_v_q & take2;
  assign s2_go    = s2_v_q & out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (take1) begin
        s1_v_q <= in_acc & emit_ok;
      end
      if (take2) begin
        s2_v_q <= s1_v_q;
      end
      if (out_free) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  // ------------------------------------------------------------------
  // Stage 1: pick the upper pair, sum masked pixels per channel
  // ------------------------------------------------------------------
  always_comb begin
    p0 = s1_q.single_row ? s1_q.bl  : (even_rd & fm);
    p1 = s1_q.single_row ? s1_q.cur : ((s1_q.single_col ? even_rd : odd_rd) & fm);
    for (int c = 0; c < NUM_CH; c++) begin
      sum_c[c] = SUM_W'(p0 & mask_q[c]) + SUM_W'(p1 & mask_q[c])
               + SUM_W'(s1_q.bl & mask_q[c]) + SUM_W'(s1_q.cur & mask_q[c]);
    end
  end

  // ------------------------------------------------------------------
  // Stage 2: quarter each sum (8 bpp passes the upper-left pixel), drop fractions, repack
  // ------------------------------------------------------------------
  always_comb begin
    acc = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      acc = acc + (s2_sum_q[c][SUM_W-1:2] & keep_q[c]);
    end
    res = ((fmt_q == FMT_8BPP) ? s2_pal_q : acc) & fm;
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q.bl         <= bl;
      s1_q.cur        <= cur;
      s1_q.single_row <= single_row;
      s1_q.single_col <= single_col;
      s1_q.row_end    <= last_col;
      s1_q.frame_end  <= last_col & last_row;
    end
    if (s1_go) begin
      s2_sum_q       <= sum_c;
      s2_pal_q       <= p0;
      s2_row_end_q   <= s1_q.row_end;
      s2_frame_end_q <= s1_q.frame_end;
    end
    if (s2_go) begin
      out_pixel_q     <= res;
      out_row_end_q   <= s2_row_end_q;
      out_frame_end_q <= s2_frame_end_q;
    end
  end

  assign dst_o.valid     = out_v_q;
  assign dst_o.out_pixel = out_pixel_q;
  assign dst_o.row_end   = out_row_end_q;
  assign dst_o.frame_end = out_frame_end_q;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  a_bank_no_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> !(we_even || we_odd))
    else $error("line bank read and write in the same cycle");

  a_read_odd_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> row_eff[0])
    else $error("line bank read outside an odd row");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !take2) |=> (s1_v_q && !src_i.ready) || take2)
    else $error("stage 1 lost a stalled request");

  a_frame_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_go && s2_frame_end_q) |=> dst_o.row_end)
    else $error("frame end without row end");

endmodule

`default_nettype wire

FILE: sim/pphd_raster_checker.sv
// ----------------------------------------------------------------------------
// Packed pixel half downscaler checker
// Watches the register port and both request channels, keeps its own copy of
// the registers, the line store and the raster position, predicts each
// downscaled pixel and compares it field by field with what the block sends.
// ----------------------------------------------------------------------------
module pphd_raster_checker
  import pphd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,
  pphd_in_if                   src_mon,
  pphd_out_if                  dst_mon,
  output int unsigned          outstanding_o,
  output int unsigned          faults_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_W      = DEF_MAX_WIDTH;
  localparam int unsigned MAX_H      = DEF_MAX_HEIGHT;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             row_end;
    logic             frame_end;
  } scaled_px_t;

  // Register copy
  pix_fmt_e          fmt;
  logic [PIX_W-1:0]  chan_mask [NUM_CH];
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;

  // Line store and raster position
  logic [PIX_W-1:0]  upper_row [MAX_W];
  logic [PIX_W-1:0]  left_px;
  int unsigned       col_cnt;
  int unsigned       row_cnt;

  scaled_px_t        pending_pixels [$];
  int unsigned       fault_tally = 0;

  function automatic int unsigned clamp_dim(logic [SIZE_W-1:0] v, int unsigned lim);
    if (v == '0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] format_bits(pix_fmt_e f);
    case (f)
      FMT_8BPP:  return 32'h0000_00FF;
      FMT_16BPP: return 32'h0000_FFFF;
      FMT_24BPP: return 32'h00FF_FFFF;
      default:   return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Sum one channel over the four pixels, quarter it and put it back in place
  function automatic logic [PIX_W-1:0] channel_quarter(logic [PIX_W-1:0] m,
                                                       logic [3:0][PIX_W-1:0] quad);
    int unsigned      sh;
    int unsigned      i;
    logic [SUM_W-1:0] acc;
    logic [PIX_W-1:0] avg;
    sh = 0;
    if (m != '0) begin
      while (m[sh] == 1'b0) sh++;
    end
    acc = '0;
    for (i = 0; i < 4; i++) begin
      acc += SUM_W'((quad[i] & m) >> sh);
    end
    avg = acc[SUM_W-1:2];
    return avg << sh;
  endfunction

  task automatic report_fault(input string msg);
    fault_tally++;
    $display("%s", msg);
  endtask

  // Take one source pixel, queue the block result it completes, advance
  task automatic advance_raster(input logic [PIX_W-1:0] raw);
    int unsigned           w;
    int unsigned           h;
    int unsigned           c;
    int unsigned           r;
    int unsigned           lc;
    logic [PIX_W-1:0]      fm;
    logic [PIX_W-1:0]      cur;
    logic [PIX_W-1:0]      bl;
    logic [PIX_W-1:0]      sum;
    logic [3:0][PIX_W-1:0] quad;
    logic                  last_c;
    logic                  last_r;
    logic                  lone_c;
    logic                  lone_r;
    scaled_px_t            px;
    w   = clamp_dim(width_reg, MAX_W);
    h   = clamp_dim(height_reg, MAX_H);
    fm  = format_bits(fmt);
    cur = raw & fm;
    // a counter left beyond a shrunk size restarts at zero
    if (col_cnt >= w) col_cnt = 0;
    if (row_cnt >= h) row_cnt = 0;
    c      = col_cnt;
    r      = row_cnt;
    last_c = (c == w - 1);
    last_r = (r == h - 1);
    lone_c = last_c && ((c & 1) == 0);
    lone_r = last_r && ((r & 1) == 0);
    if ((((c & 1) != 0) || lone_c) && (((r & 1) != 0) || lone_r) && !(w == 1 && h == 1)) begin
      lc = lone_c ? c : c - 1;
      bl = lone_c ? cur : (left_px & fm);
      if (lone_r) begin
        quad[0] = bl;
        quad[1] = cur;
      end else begin
        quad[0] = upper_row[lc] & fm;
        quad[1] = upper_row[c] & fm;
      end
      quad[2] = bl;
      quad[3] = cur;
      if (fmt == FMT_8BPP) begin
        sum = quad[0];
      end else begin
        sum = channel_quarter(chan_mask[CH_ALPHA], quad)
            + channel_quarter(chan_mask[CH_RED], quad)
            + channel_quarter(chan_mask[CH_GREEN], quad)
            + channel_quarter(chan_mask[CH_BLUE], quad);
      end
      px.pixel     = sum & fm;
      px.row_end   = last_c;
      px.frame_end = last_c && last_r;
      pending_pixels.push_back(px);
    end
    if ((r & 1) == 0) upper_row[c] = cur;
    left_px = cur;
    if (last_c) begin
      col_cnt = 0;
      row_cnt = last_r ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
  endtask

  // Track registers, check results, then predict from accepted requests
  always @(posedge clk_i or negedge rst_ni) begin
    scaled_px_t want;
    if (!rst_ni) begin
      fmt                  = RST_FORMAT;
      chan_mask[CH_ALPHA]  = RST_ALPHA_MASK;
      chan_mask[CH_RED]    = RST_RED_MASK;
      chan_mask[CH_GREEN]  = RST_GREEN_MASK;
      chan_mask[CH_BLUE]   = RST_BLUE_MASK;
      width_reg            = 12'd1;
      height_reg           = 12'd1;
      left_px              = '0;
      col_cnt              = 0;
      row_cnt              = 0;
      pending_pixels.delete();
      outstanding_o       <= 0;
      faults_o            <= fault_tally;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PIXEL_FORMAT:  fmt                 = pix_fmt_e'(cfg_wdata_i[1:0]);
          CFG_ALPHA_MASK:    chan_mask[CH_ALPHA] = cfg_wdata_i;
          CFG_RED_MASK:      chan_mask[CH_RED]   = cfg_wdata_i;
          CFG_GREEN_MASK:    chan_mask[CH_GREEN] = cfg_wdata_i;
          CFG_BLUE_MASK:     chan_mask[CH_BLUE]  = cfg_wdata_i;
          CFG_SOURCE_WIDTH:  width_reg           = cfg_wdata_i[SIZE_W-1:0];
          CFG_SOURCE_HEIGHT: height_reg          = cfg_wdata_i[SIZE_W-1:0];
          default: ;
        endcase
      end
      if (dst_mon.valid && dst_mon.ready) begin
        if (pending_pixels.size() == 0) begin
          report_fault($sformatf("%0t: result with none expected, actual out_pixel %08h",
                                 $time, dst_mon.out_pixel));
        end else begin
          want = pending_pixels.pop_front();
          if (dst_mon.out_pixel !== want.pixel)
            report_fault($sformatf("%0t: out_pixel expected %08h actual %08h",
                                   $time, want.pixel, dst_mon.out_pixel));
          if (dst_mon.row_end !== want.row_end)
            report_fault($sformatf("%0t: row_end expected %b actual %b",
                                   $time, want.row_end, dst_mon.row_end));
          if (dst_mon.frame_end !== want.frame_end)
            report_fault($sformatf("%0t: frame_end expected %b actual %b",
                                   $time, want.frame_end, dst_mon.frame_end));
        end
      end
      if (src_mon.valid && src_mon.ready) advance_raster(src_mon.source_pixel);
      outstanding_o <= pending_pixels.size();
      faults_o      <= fault_tally;
    end
  end

endmodule

FILE: sim/tb_packed_pixel_half_downscaler_top.sv
// ----------------------------------------------------------------------------
// Packed pixel half downscaler testbench
// Drives source pixels and register writes into the downscaler, stalls the
// result side at random, and leaves prediction and comparison to the checker
// beside it. Directed frames cover every format and the edge sizes; random
// phases then vary registers, frame sizes, mid-frame shrinks and sizes above
// the limit while the result side backs the block up.
// ----------------------------------------------------------------------------
module tb_packed_pixel_half_downscaler_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pphd_pkg::*;

  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned RANDOM_ITEMS  = 500;
  localparam int unsigned IDLE_PCT      = 22;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DAT_W-1:0] cfg_wdata;

  int unsigned outstanding;
  int unsigned fault_count;
  int unsigned sent_random  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned big_frames   = 0;

  pphd_in_if  src_if ();
  pphd_out_if dst_if ();

  always #5ns clk_i = ~clk_i;

  packed_pixel_half_downscaler_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .src_i       (src_if),
    .dst_o       (dst_if)
  );

  pphd_raster_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .src_mon       (src_if),
    .dst_mon       (dst_if),
    .outstanding_o (outstanding),
    .faults_o      (fault_count)
  );

  // Hold the write enable high; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
  endtask

  // Write every register; unused upper bits carry noise
  task automatic configure(input pix_fmt_e f, input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] r,
                           input logic [PIX_W-1:0] g, input logic [PIX_W-1:0] b,
                           input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
    write_reg(CFG_PIXEL_FORMAT, {30'($urandom()), 2'(f)});
    write_reg(CFG_ALPHA_MASK, a);
    write_reg(CFG_RED_MASK, r);
    write_reg(CFG_GREEN_MASK, g);
    write_reg(CFG_BLUE_MASK, b);
    write_reg(CFG_SOURCE_WIDTH, {20'($urandom()), w});
    write_reg(CFG_SOURCE_HEIGHT, {20'($urandom()), h});
    cfg_we <= 1'b0;
  endtask

  // Offer one pixel, idling at random first unless sent_random is in 150..299, and return once it is taken
  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    if (!(sent_random >= 150 && sent_random < 300)) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        src_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    src_if.valid        <= 1'b1;
    src_if.source_pixel <= pix;
    @(posedge clk_i);
    while (!src_if.ready) @(posedge clk_i);
  endtask

  task automatic send_pixels(input int unsigned n);
    repeat (n) send_pixel($urandom());
  endtask

  // Stop offering, wait for every result, then let the pipeline settle
  task automatic drain();
    src_if.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly contiguous masks; now and then zero, all ones or scattered bits
  function automatic logic [PIX_W-1:0] pick_mask();
    int unsigned lsb;
    int unsigned len;
    logic [63:0] field;
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return $urandom();
      default: begin
        lsb   = $urandom_range(31);
        len   = $urandom_range(1, 32 - lsb);
        field = ((64'd1 << len) - 64'd1) << lsb;
        return field[PIX_W-1:0];
      end
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] pick_dim();
    case ($urandom_range(9))
      0:       return '0;
      1:       return SIZE_W'($urandom_range(10, 24));
      default: return SIZE_W'($urandom_range(1, 8));
    endcase
  endfunction

  // Result side: random stalls, a calm stretch, and a long hold-off at the
  // start of the saturated-height frame so the block fills up
  initial begin : result_sink
    int unsigned taken;
    int unsigned holds;
    taken = 0;
    holds = 0;
    dst_if.ready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (dst_if.valid && dst_if.ready) taken++;
      if (holds < big_frames) begin
        holds++;
        dst_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      dst_if.ready <= (taken >= 100 && taken < 250) || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((src_if.valid && src_if.ready) || (dst_if.valid && dst_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("packed_pixel_half_downscaler_top verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned       i;
    int unsigned       phase;
    int unsigned       frames;
    int unsigned       area;
    int unsigned       w0;
    int unsigned       h0;
    int unsigned       r;
    int unsigned       c;
    int unsigned       nsz;
    int unsigned       remain;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    rst_ni              <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= CFG_PIXEL_FORMAT;
    cfg_wdata           <= '0;
    src_if.valid        <= 1'b0;
    src_if.source_pixel <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single pixel frame on the reset registers: nothing comes out
    send_pixel(32'hFFFF_FFFF);
    drain();

    // 2x2 through the reset ARGB masks
    write_reg(CFG_SOURCE_WIDTH, 32'd2);
    write_reg(CFG_SOURCE_HEIGHT, 32'd2);
    cfg_we <= 1'b0;
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h8000_0001);
    drain();

    // palette, odd last column and row replicated
    configure(FMT_8BPP, '1, '1, '1, '1, 12'd3, 12'd3);
    for (i = 0; i < 9; i++) begin
      case (i % 3)
        0:       send_pixel(32'hFFFF_FFFF);
        1:       send_pixel(32'h0000_0000);
        default: send_pixel($urandom());
      endcase
    end
    drain();

    // 16 bpp, zero alpha, overlapping and scattered masks, width 0 taken as 1
    configure(FMT_16BPP, 32'h0, 32'h0000_F0F0, 32'h0000_FF00, 32'hFFFF_FFFF, 12'd0, 12'd2);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'hFFFF_FFFF);
    drain();

    // 24 bpp, height 0 taken as 1
    configure(FMT_24BPP, RST_ALPHA_MASK, RST_RED_MASK, RST_GREEN_MASK, RST_BLUE_MASK,
              12'd3, 12'd0);
    send_pixel(32'h00FF_FFFF);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h0000_0000);
    drain();

    phase = 0;
    while (sent_random < RANDOM_ITEMS) begin
      if (phase == 3) begin
        // height above the limit saturates; a shrink ends the frame early
        w0 = $urandom_range(4, 8);
        configure(pix_fmt_e'($urandom_range(3)), pick_mask(), pick_mask(), pick_mask(),
                  pick_mask(), SIZE_W'(w0),
                  SIZE_W'($urandom_range(DEF_MAX_HEIGHT + 1, 4095)));
        big_frames <= big_frames + 1;
        r   = $urandom_range(8, 12);
        nsz = $urandom_range(1, r);
        send_pixels(r * w0);
        drain();
        write_reg(CFG_SOURCE_HEIGHT, CFG_DAT_W'(nsz));
        cfg_we <= 1'b0;
        remain = nsz * w0;
        send_pixels(remain);
        sent_random += r * w0 + remain;
      end else if (phase == 6) begin
        // width above the limit saturates; a shrink ends the first row early
        h0  = $urandom_range(2, 4);
        c   = $urandom_range(20, 60);
        nsz = $urandom_range(1, 8);
        configure(pix_fmt_e'($urandom_range(3)), pick_mask(), pick_mask(), pick_mask(),
                  pick_mask(), SIZE_W'($urandom_range(DEF_MAX_WIDTH + 1, 4095)),
                  SIZE_W'(h0));
        send_pixels(c);
        drain();
        write_reg(CFG_SOURCE_WIDTH, CFG_DAT_W'(nsz));
        cfg_we <= 1'b0;
        remain = h0 * nsz;
        send_pixels(remain);
        sent_random += c + remain;
      end else if (phase < 2 || $urandom_range(5) == 0) begin
        // stop mid-frame, shrink one size below the position, finish the frame
        w0 = $urandom_range(4, 8);
        h0 = $urandom_range(4, 8);
        configure(pix_fmt_e'($urandom_range(3)), pick_mask(), pick_mask(), pick_mask(),
                  pick_mask(), SIZE_W'(w0), SIZE_W'(h0));
        if ((phase < 2) ? (phase == 0) : ($urandom_range(1) == 0)) begin
          r   = $urandom_range(0, h0 - 1);
          c   = $urandom_range(1, w0 - 1);
          nsz = $urandom_range(1, c);
          send_pixels(r * w0 + c);
          drain();
          write_reg(CFG_SOURCE_WIDTH, CFG_DAT_W'(nsz));
          remain = (h0 - r) * nsz;
        end else begin
          r   = $urandom_range(1, h0 - 1);
          c   = $urandom_range(0, w0 - 1);
          nsz = $urandom_range(1, r);
          send_pixels(r * w0 + c);
          drain();
          write_reg(CFG_SOURCE_HEIGHT, CFG_DAT_W'(nsz));
          remain = nsz * w0 - c;
        end
        cfg_we <= 1'b0;
        send_pixels(remain);
        sent_random += r * w0 + c + remain;
      end else begin
        // whole frames with random registers
        w = pick_dim();
        h = pick_dim();
        configure(pix_fmt_e'($urandom_range(3)), pick_mask(), pick_mask(), pick_mask(),
                  pick_mask(), w, h);
        area   = ((w == '0) ? 1 : int'(w)) * ((h == '0) ? 1 : int'(h));
        frames = $urandom_range(1, 3);
        repeat (frames) send_pixels(area);
        sent_random += frames * area;
      end
      drain();
      phase++;
    end

    repeat (10) @(posedge clk_i);
    if (fault_count == 0 && outstanding == 0) begin
      $display("packed_pixel_half_downscaler_top verification clean");
    end else begin
      $display("packed_pixel_half_downscaler_top verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/pphd_pkg.sv
design/pphd_if.sv
design/pphd_ram.sv
design/packed_pixel_half_downscaler_top.sv
sim/pphd_raster_checker.sv
sim/tb_packed_pixel_half_downscaler_top.sv
